// File: rtl/core/rpn_pkg.sv
// Shared types and constants for the reverse Polish notation stack evaluator.
`default_nettype none

package rpn_pkg;

  // ASCII codes the front end recognises
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_EQUAL = 8'h3D;

  // Decoupling queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Result status codes
  typedef enum logic [2:0] {
    STAT_OK    = 3'd0,
    STAT_SPACE = 3'd1,
    STAT_VALUE = 3'd2,
    STAT_OVER  = 3'd3,
    STAT_UNDER = 3'd4,
    STAT_MANY  = 3'd5,
    STAT_DIV0  = 3'd6,
    STAT_QUIT  = 3'd7
  } rpn_status_e;

  // Symbol classes produced by the front end
  typedef enum logic [2:0] {
    OP_DIGIT = 3'd0,
    OP_ADD   = 3'd1,
    OP_SUB   = 3'd2,
    OP_MUL   = 3'd3,
    OP_DIV   = 3'd4,
    OP_EQ    = 3'd5,
    OP_SPACE = 3'd6,
    OP_QUIT  = 3'd7
  } rpn_op_e;

  // Back-end sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_DIV_WAIT
  } rpn_state_e;

  // One classified symbol
  typedef struct packed {
    rpn_op_e    op;
    logic [3:0] digit;
  } rpn_item_t;

  // Queue write side, front to queue
  typedef struct packed {
    logic      valid;
    rpn_item_t item;
  } rpn_push_t;

  // Queue read side, queue to back
  typedef struct packed {
    logic      valid;
    rpn_item_t item;
  } rpn_head_t;

endpackage

`default_nettype wire

// File: rtl/core/rpn_stack_evaluator.sv
// Path: symbol -> queue -> back-end sequencer -> result register. Digits, blanks, '=' and stack
// errors load the result in S_IDLE, + - * and divide by zero in S_EXEC, / in S_DIV_WAIT.
// Throughput: one symbol per cycle for non-arithmetic symbols while the result side is not stalled;
// + - * and / hold the sequencer until loaded; the divider gives one quotient bit per cycle.
// Reset: stack empty, queue and result valid flag cleared; stack storage and result payload are not cleared.
`default_nettype none

module rpn_stack_evaluator #(
  parameter int unsigned STACK_DEPTH = 128
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] symbol
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata    // [2:0] status, [10:3] value, [18:11] stack_depth
);

  rpn_pkg::rpn_push_t   push;
  rpn_pkg::rpn_head_t   head;
  logic                 q_full, q_pop;
  rpn_pkg::rpn_status_e status;
  logic [7:0]           value, depth;

  rpn_front u_front (
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .symbol_i  (s_axis_tdata),
    .q_full_i  (q_full),
    .push_o    (push)
  );

  rpn_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .full_o (q_full),
    .head_o (head),
    .pop_i  (q_pop)
  );

  rpn_back #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head),
    .pop_o        (q_pop),
    .out_ready_i  (m_axis_tready),
    .out_valid_o  (m_axis_tvalid),
    .out_status_o (status),
    .out_value_o  (value),
    .out_depth_o  (depth)
  );

  assign m_axis_tdata = {5'b00000, depth, value, status};

`ifndef NO_ASSERTIONS
  // Value is only non-zero on a delivered expression value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (status != rpn_pkg::STAT_VALUE) |-> value == '0)
    else $error("value non-zero on non-value result");

  // Errors and '=' leave the stack empty
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (status == rpn_pkg::STAT_OVER || status == rpn_pkg::STAT_UNDER ||
      status == rpn_pkg::STAT_MANY || status == rpn_pkg::STAT_DIV0 ||
      status == rpn_pkg::STAT_QUIT || status == rpn_pkg::STAT_VALUE) |-> depth == '0)
    else $error("stack not cleared after error or value");

  // Back end never pops an empty queue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> head.valid)
    else $error("pop from empty queue");

  // Front never pushes into a full queue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push.valid |-> !q_full)
    else $error("push into full queue");
`endif

endmodule

`default_nettype wire

// File: rtl/core/rpn_front.sv
// Front end: accepts ASCII symbols and classifies them into operations.
`default_nettype none

module rpn_front (
  input  wire logic              s_valid_i,
  output logic                   s_ready_o,
  input  wire logic [7:0]        symbol_i,
  input  wire logic              q_full_i,
  output rpn_pkg::rpn_push_t     push_o
);

  rpn_pkg::rpn_item_t item;

  // Classify the incoming character
  always_comb begin
    item.op    = rpn_pkg::OP_QUIT;
    item.digit = '0;
    if (symbol_i == rpn_pkg::CH_SPACE ||
        (symbol_i >= rpn_pkg::CH_TAB && symbol_i <= rpn_pkg::CH_CR)) begin
      item.op = rpn_pkg::OP_SPACE;
    end else if (symbol_i >= rpn_pkg::CH_ZERO && symbol_i <= rpn_pkg::CH_NINE) begin
      item.op    = rpn_pkg::OP_DIGIT;
      item.digit = 4'(symbol_i - rpn_pkg::CH_ZERO);
    end else begin
      case (symbol_i)
        rpn_pkg::CH_PLUS:  item.op = rpn_pkg::OP_ADD;
        rpn_pkg::CH_MINUS: item.op = rpn_pkg::OP_SUB;
        rpn_pkg::CH_STAR:  item.op = rpn_pkg::OP_MUL;
        rpn_pkg::CH_SLASH: item.op = rpn_pkg::OP_DIV;
        rpn_pkg::CH_EQUAL: item.op = rpn_pkg::OP_EQ;
        default:           item.op = rpn_pkg::OP_QUIT;
      endcase
    end
  end

  // Accept whenever the queue has room
  assign s_ready_o    = !q_full_i;
  assign push_o.valid = s_valid_i && !q_full_i;
  assign push_o.item  = item;

endmodule

`default_nettype wire

// File: rtl/core/rpn_fifo.sv
// Short queue of classified symbols between front and back end.
`default_nettype none

module rpn_fifo (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire rpn_pkg::rpn_push_t push_i,
  output logic                    full_o,
  output rpn_pkg::rpn_head_t      head_o,
  input  wire logic               pop_i
);

  rpn_pkg::rpn_item_t                  entry_q [rpn_pkg::QUEUE_DEPTH];
  logic [rpn_pkg::QPTR_W-1:0]          wr_ptr_q, wr_ptr_d;
  logic [rpn_pkg::QPTR_W-1:0]          rd_ptr_q, rd_ptr_d;
  logic [rpn_pkg::QCNT_W-1:0]          cnt_q, cnt_d;
  logic                                do_push, do_pop;

  assign full_o      = (cnt_q == rpn_pkg::QCNT_W'(rpn_pkg::QUEUE_DEPTH));
  assign head_o.valid = (cnt_q != '0);
  assign head_o.item  = entry_q[rd_ptr_q];

  assign do_push = push_i.valid && !full_o;
  assign do_pop  = pop_i && head_o.valid;

  // Pointer and count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == rpn_pkg::QPTR_W'(rpn_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                          : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == rpn_pkg::QPTR_W'(rpn_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                          : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_i.item;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/rpn_div.sv
// Iterative signed 8-bit divider, one quotient bit per cycle, truncating toward zero.
`default_nettype none

module rpn_div (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       start_i,
  input  wire logic [7:0] dividend_i,
  input  wire logic [7:0] divisor_i,
  output logic            busy_o,
  output logic [7:0]      quotient_o
);

  logic       busy_q, busy_d;
  logic [2:0] cnt_q, cnt_d;
  logic       neg_q;
  logic [7:0] quo_q, rem_q, den_q;
  logic [8:0] shifted;
  logic [9:0] diff;
  logic       ge;

  // One restoring step
  assign shifted = {rem_q, quo_q[7]};
  assign diff    = {1'b0, shifted} - {2'b00, den_q};
  assign ge      = !diff[9];

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = 3'd7;
    end else if (busy_q) begin
      cnt_d = cnt_q - 3'd1;
      if (cnt_q == 3'd0) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  // Datapath: magnitudes in, sign fixed up at the output
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= dividend_i[7] ^ divisor_i[7];
      quo_q <= dividend_i[7] ? 8'(-dividend_i) : dividend_i;
      den_q <= divisor_i[7] ? 8'(-divisor_i) : divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      rem_q <= ge ? diff[7:0] : shifted[7:0];
      quo_q <= {quo_q[6:0], ge};
    end
  end

  assign busy_o     = busy_q;
  assign quotient_o = neg_q ? 8'(-quo_q) : quo_q;

endmodule

`default_nettype wire

// File: rtl/core/rpn_back.sv
// Back end: operand stack, arithmetic sequencer and result register.
`default_nettype none

module rpn_back #(
  parameter int unsigned STACK_DEPTH = 128
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire rpn_pkg::rpn_head_t head_i,
  output logic                    pop_o,
  input  wire logic               out_ready_i,
  output logic                    out_valid_o,
  output rpn_pkg::rpn_status_e    out_status_o,
  output logic [7:0]              out_value_o,
  output logic [7:0]              out_depth_o
);

  localparam int unsigned SP_W = $clog2(STACK_DEPTH + 1);
  localparam int unsigned AW   = $clog2(STACK_DEPTH);

  // Entries below the top of stack; the top lives in tos_q
  logic [7:0]            stack_mem [STACK_DEPTH];
  logic [7:0]            rd_q;
  logic [AW-1:0]         rd_addr, wr_addr;
  logic                  wr_en;

  rpn_pkg::rpn_state_e   state_q, state_d;
  logic [SP_W-1:0]       sp_q, sp_d;
  logic [7:0]            tos_q, tos_d;
  rpn_pkg::rpn_op_e      op_q, op_d;

  logic                  out_valid_q, out_valid_d;
  rpn_pkg::rpn_status_e  out_status_q, res_status;
  logic [7:0]            out_value_q, res_value;
  logic [7:0]            out_depth_q;
  logic                  out_free, load;

  logic signed [15:0]    prod;
  logic [7:0]            alu_res;
  logic                  div_start, div_busy;
  logic [7:0]            div_quo;

  assign rd_addr  = AW'(sp_q - SP_W'(2));
  assign wr_addr  = AW'(sp_q - SP_W'(1));
  assign out_free = !out_valid_q || out_ready_i;

  // Second operand read, registered
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      stack_mem[wr_addr] <= tos_q;
    end
    rd_q <= stack_mem[rd_addr];
  end

  // Add, subtract, multiply on left = rd_q, right = tos_q
  assign prod = $signed(rd_q) * $signed(tos_q);

  always_comb begin
    case (op_q)
      rpn_pkg::OP_ADD: alu_res = rd_q + tos_q;
      rpn_pkg::OP_SUB: alu_res = rd_q - tos_q;
      rpn_pkg::OP_MUL: alu_res = prod[7:0];
      default:         alu_res = '0;
    endcase
  end

  rpn_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (rd_q),
    .divisor_i  (tos_q),
    .busy_o     (div_busy),
    .quotient_o (div_quo)
  );

  // Sequencer: next state, stack update and result
  always_comb begin
    state_d    = state_q;
    sp_d       = sp_q;
    tos_d      = tos_q;
    op_d       = op_q;
    wr_en      = 1'b0;
    pop_o      = 1'b0;
    div_start  = 1'b0;
    load       = 1'b0;
    res_status = rpn_pkg::STAT_OK;
    res_value  = '0;
    unique case (state_q)
      rpn_pkg::S_IDLE: begin
        if (head_i.valid && out_free) begin
          pop_o = 1'b1;
          unique case (head_i.item.op) inside
            rpn_pkg::OP_SPACE: begin
              load       = 1'b1;
              res_status = rpn_pkg::STAT_SPACE;
            end
            rpn_pkg::OP_DIGIT: begin
              load = 1'b1;
              if (sp_q == SP_W'(STACK_DEPTH)) begin
                res_status = rpn_pkg::STAT_OVER;
                sp_d       = '0;
              end else begin
                wr_en = (sp_q != '0);
                tos_d = {4'b0000, head_i.item.digit};
                sp_d  = sp_q + 1'b1;
              end
            end
            rpn_pkg::OP_ADD, rpn_pkg::OP_SUB, rpn_pkg::OP_MUL, rpn_pkg::OP_DIV: begin
              if (sp_q < SP_W'(2)) begin
                load       = 1'b1;
                res_status = rpn_pkg::STAT_UNDER;
                sp_d       = '0;
              end else begin
                op_d    = head_i.item.op;
                state_d = rpn_pkg::S_EXEC;
              end
            end
            rpn_pkg::OP_EQ: begin
              load = 1'b1;
              sp_d = '0;
              if (sp_q == '0) begin
                res_status = rpn_pkg::STAT_UNDER;
              end else if (sp_q == SP_W'(1)) begin
                res_status = rpn_pkg::STAT_VALUE;
                res_value  = tos_q;
              end else begin
                res_status = rpn_pkg::STAT_MANY;
              end
            end
            default: begin
              load       = 1'b1;
              res_status = rpn_pkg::STAT_QUIT;
              sp_d       = '0;
            end
          endcase
        end
      end
      rpn_pkg::S_EXEC: begin
        if (op_q == rpn_pkg::OP_DIV) begin
          if (tos_q == '0) begin
            if (out_free) begin
              load       = 1'b1;
              res_status = rpn_pkg::STAT_DIV0;
              sp_d       = '0;
              state_d    = rpn_pkg::S_IDLE;
            end
          end else begin
            div_start = 1'b1;
            state_d   = rpn_pkg::S_DIV_WAIT;
          end
        end else if (out_free) begin
          load    = 1'b1;
          tos_d   = alu_res;
          sp_d    = sp_q - 1'b1;
          state_d = rpn_pkg::S_IDLE;
        end
      end
      rpn_pkg::S_DIV_WAIT: begin
        if (!div_busy && out_free) begin
          load    = 1'b1;
          tos_d   = div_quo;
          sp_d    = sp_q - 1'b1;
          state_d = rpn_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = rpn_pkg::S_IDLE;
      end
    endcase
  end

  assign out_valid_d = load || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rpn_pkg::S_IDLE;
      sp_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sp_q        <= sp_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    tos_q <= tos_d;
    op_q  <= op_d;
    if (load) begin
      out_status_q <= res_status;
      out_value_q  <= res_value;
      out_depth_q  <= 8'(sp_d);
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_status_o = out_status_q;
  assign out_value_o  = out_value_q;
  assign out_depth_o  = out_depth_q;

endmodule

`default_nettype wire

// File: tb/tb.sv
// Self-checking testbench for rpn_stack_evaluator: symbol streams checked against a stack model.
module tb;
  import rpn_pkg::*;

  localparam int unsigned STACK_DEPTH   = 128;
  localparam int unsigned IDX_W         = $clog2(STACK_DEPTH);
  localparam int unsigned ITEM_TARGET   = 1550;
  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned DRAIN_LIMIT   = 2000;
  localparam int unsigned SETTLE_CYCLES = 16;
  localparam int unsigned MAX_GAP       = 20;
  localparam int unsigned REPORT_LIMIT  = 10;

  // How a deep stack run ends once every entry is in use
  typedef enum int unsigned {
    FILL_OVERFLOW,
    FILL_TOO_MANY,
    FILL_REDUCE
  } fill_end_e;

  // One result transaction, status in the lowest bits as on the bus
  typedef struct packed {
    logic [7:0]  depth;
    logic [7:0]  value;
    rpn_status_e status;
  } rpn_result_t;

  // Stack model plus the queue of results still owed by the block
  class eval_scoreboard;
    logic [7:0]  model_stack [STACK_DEPTH];
    int unsigned model_sp;
    rpn_result_t pending_results [$];
    int unsigned results_checked;
    int unsigned mismatches;
    int unsigned status_hits [8];

    function new();
      model_sp        = 0;
      results_checked = 0;
      mismatches      = 0;
      foreach (status_hits[i]) status_hits[i] = 0;
    endfunction

    // Apply one symbol to the model stack and return the result it gives
    function rpn_result_t evaluate_symbol(logic [7:0] sym);
      rpn_result_t res;
      int          lhs;
      int          rhs;
      int          acc;
      res.status = STAT_OK;
      res.value  = '0;
      acc        = 0;
      if (sym == CH_SPACE || (sym >= CH_TAB && sym <= CH_CR)) begin
        res.status = STAT_SPACE;
      end else if (sym >= CH_ZERO && sym <= CH_NINE) begin
        if (model_sp >= STACK_DEPTH) begin
          res.status = STAT_OVER;
          model_sp   = 0;
        end else begin
          model_stack[IDX_W'(model_sp)] = sym - CH_ZERO;
          model_sp++;
        end
      end else if (sym == CH_PLUS || sym == CH_MINUS || sym == CH_STAR || sym == CH_SLASH) begin
        if (model_sp < 2) begin
          res.status = STAT_UNDER;
          model_sp   = 0;
        end else begin
          lhs = int'($signed(model_stack[IDX_W'(model_sp - 2)]));
          rhs = int'($signed(model_stack[IDX_W'(model_sp - 1)]));
          case (sym)
            CH_PLUS:  acc = lhs + rhs;
            CH_MINUS: acc = lhs - rhs;
            CH_STAR:  acc = lhs * rhs;
            default:  acc = (rhs == 0) ? 0 : lhs / rhs;
          endcase
          if (sym == CH_SLASH && rhs == 0) begin
            res.status = STAT_DIV0;
            model_sp   = 0;
          end else begin
            // two popped, result lands in the lower slot; wraps to 8 bits
            model_sp--;
            model_stack[IDX_W'(model_sp - 1)] = acc[7:0];
          end
        end
      end else if (sym == CH_EQUAL) begin
        if (model_sp == 0) begin
          res.status = STAT_UNDER;
        end else if (model_sp > 1) begin
          res.status = STAT_MANY;
        end else begin
          res.status = STAT_VALUE;
          res.value  = model_stack[0];
        end
        model_sp = 0;
      end else begin
        res.status = STAT_QUIT;
        model_sp   = 0;
      end
      res.depth = model_sp[7:0];
      return res;
    endfunction

    function void note_symbol(logic [7:0] sym);
      pending_results.push_back(evaluate_symbol(sym));
    endfunction

    // Compare one result transaction with the oldest expectation
    function void check_result(logic [23:0] word);
      rpn_result_t want;
      rpn_result_t got;
      got = word[18:0];
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("unexpected result: status %0d value %0d depth %0d",
                   got.status, $signed(got.value), got.depth);
        return;
      end
      want = pending_results.pop_front();
      results_checked++;
      status_hits[want.status]++;
      if (got.status !== want.status || got.value !== want.value ||
          got.depth !== want.depth || word[23:19] !== '0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display({"mismatch at result %0d: expected status %0d value %0d depth %0d,",
                    " got status %0d value %0d depth %0d pad %0h"},
                   results_checked, want.status, $signed(want.value), want.depth,
                   got.status, $signed(got.value), got.depth, word[23:19]);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;   // [7:0] symbol
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b1;
  logic [23:0] m_axis_tdata;        // [2:0] status, [10:3] value, [18:11] stack_depth

  eval_scoreboard sb;
  int unsigned    items_sent = 0;
  int unsigned    src_idle_pct = 33;
  int unsigned    snk_idle_pct = 58;
  int unsigned    cycle_count = 0;
  logic [7:0]     op_chars [4] = '{CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH};

  rpn_stack_evaluator #(
    .STACK_DEPTH(STACK_DEPTH)
  ) u_dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  // Clock and a single reset pulse
  initial forever #10 clk = ~clk;

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  // Watchdog
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("timeout after %0d cycles", cycle_count);
    $display("tb: errors");
    $finish;
  end

  // Result side: check each transaction, stall at random
  initial begin
    forever begin
      @(posedge clk);
      if (rst_n && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
      m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  function automatic logic [7:0] digit_char(int unsigned n);
    return CH_ZERO + n[7:0];
  endfunction

  function automatic logic [7:0] random_digit();
    return digit_char($urandom_range(9));
  endfunction

  function automatic logic [7:0] random_blank();
    if ($urandom_range(3) == 0) return CH_SPACE;
    return 8'($urandom_range(CH_TAB, CH_CR));
  endfunction

  function automatic logic [7:0] random_op(int unsigned top);
    return op_chars[2'($urandom_range(top))];
  endfunction

  // Drive one symbol, optionally after a random gap, and wait for acceptance
  task automatic send_symbol(input logic [7:0] sym);
    int unsigned gap;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < src_idle_pct) gap++;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= sym;
    do @(posedge clk); while (!s_axis_tready);
    sb.note_symbol(sym);
    items_sent++;
  endtask

  // Symbol with the odd blank slipped in ahead of it
  task automatic send_token(input logic [7:0] sym);
    if ($urandom_range(7) == 0) send_symbol(random_blank());
    send_symbol(sym);
  endtask

  // Well-formed expression of random shape, closed by '='
  task automatic send_expression();
    int unsigned pushes;
    int unsigned depth;
    pushes = $urandom_range(1, 10);
    depth  = 0;
    while (pushes != 0 || depth > 1) begin
      if (depth < 2 || (pushes != 0 && $urandom_range(1) == 0)) begin
        send_token(random_digit());
        pushes--;
        depth++;
      end else begin
        send_token(random_op(3));
        depth--;
      end
    end
    send_token(CH_EQUAL);
  endtask

  // Short run of random classes, mostly malformed
  task automatic send_broken();
    int unsigned len;
    len = $urandom_range(1, 6);
    repeat (len) begin
      case ($urandom_range(3))
        0:       send_symbol(random_digit());
        1:       send_symbol(random_op(3));
        2:       send_symbol(CH_EQUAL);
        default: send_symbol(random_blank());
      endcase
    end
  endtask

  // Empty the stack, fill every entry, then overflow, collapse it or close it too early
  task automatic send_stack_fill(input fill_end_e how);
    send_symbol(CH_EQUAL);
    repeat (STACK_DEPTH) send_token(random_digit());
    case (how)
      FILL_OVERFLOW: send_symbol(random_digit());
      FILL_TOO_MANY: send_symbol(CH_EQUAL);
      default: begin
        repeat (STACK_DEPTH - 1) send_token(random_op(2));
        send_symbol(CH_EQUAL);
      end
    endcase
  endtask

  task automatic run_random(input int unsigned target);
    int unsigned pick;
    while (items_sent < target) begin
      pick = $urandom_range(99);
      if (pick < 70)
        send_expression();
      else if (pick < 85)
        send_broken();
      else
        repeat ($urandom_range(1, 3)) send_symbol(8'($urandom_range(255)));
    end
  endtask

  // Stimulus and end of run
  initial begin
    logic [7:0]  opening [$];
    int unsigned drain;
    int unsigned leftover;
    sb = new();
    // extremes, empty-stack errors, -128 / -1 wrap, divide by zero, too many, blanks
    opening = '{8'h00, 8'hFF, CH_EQUAL, CH_PLUS,
                digit_char(8), digit_char(8), CH_STAR, digit_char(2), CH_STAR,
                digit_char(0), digit_char(1), CH_MINUS, CH_SLASH, CH_EQUAL,
                digit_char(9), digit_char(0), CH_SLASH,
                digit_char(1), CH_SPACE, digit_char(2), CH_EQUAL, CH_CR, CH_TAB};
    wait (rst_n);
    @(posedge clk);

    foreach (opening[i]) send_symbol(opening[i]);
    send_stack_fill(FILL_OVERFLOW);
    run_random(ITEM_TARGET / 3);

    src_idle_pct = 58;
    snk_idle_pct = 33;
    send_stack_fill(FILL_REDUCE);
    run_random(2 * ITEM_TARGET / 3);

    src_idle_pct = 0;
    snk_idle_pct = 0;
    send_stack_fill(FILL_TOO_MANY);
    run_random(ITEM_TARGET);
    s_axis_tvalid <= 1'b0;

    drain = 0;
    while (sb.pending_results.size() != 0 && drain < DRAIN_LIMIT) begin
      @(posedge clk);
      drain++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);

    leftover = sb.pending_results.size();
    if (leftover != 0) $display("%0d expected results never arrived", leftover);
    $display("summary: %0d symbols sent, %0d results checked, %0d mismatches",
             items_sent, sb.results_checked, sb.mismatches);
    $display({"statuses seen: ok %0d, blank %0d, value %0d, overflow %0d,",
              " underflow %0d, too many %0d, div by zero %0d, quit %0d"},
             sb.status_hits[STAT_OK], sb.status_hits[STAT_SPACE], sb.status_hits[STAT_VALUE],
             sb.status_hits[STAT_OVER], sb.status_hits[STAT_UNDER], sb.status_hits[STAT_MANY],
             sb.status_hits[STAT_DIV0], sb.status_hits[STAT_QUIT]);
    if (sb.mismatches == 0 && leftover == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
